>>> hdl/pixel_sample_accumulator_defines.svh
// assertion macros for the pixel sample accumulator rtl
`ifndef PIXEL_SAMPLE_ACCUMULATOR_DEFINES_SVH
`define PIXEL_SAMPLE_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, quiet while reset is held
`define PSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psa assertion failed");
// next-cycle implication, quiet while reset is held
`define PSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psa assertion failed");
`else
`define PSA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/psa_pkg.sv
// types and constants shared by the pixel sample accumulator
`default_nettype none

package psa_pkg;

    // field widths
    localparam int COL_W = 8;
    localparam int ROW_W = 8;
    localparam int CFG_W = 9;
    localparam int SMP_W = 16;
    localparam int CNT_W = 16;
    localparam int IDX_W = 16;
    localparam int AVG_W = 13;
    localparam int SUM_W = 32;

    // color channels and their slots
    localparam int CHANNELS = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // fixed point
    localparam int FRAC_BITS = 12;
    localparam int ONE_Q12   = 1 << FRAC_BITS;

    // divider: quotient bits and bits resolved per cycle
    localparam int QUO_W     = 14;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = QUO_W / DIV_BITS;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // image width after reset
    localparam int CFG_RESET_WIDTH = 256;

    // classified request on its way to the back end
    typedef struct packed {
        logic [IDX_W-1:0]                   pixel_index;
        logic [CHANNELS-1:0][SMP_W-1:0]     sample;
        logic [CNT_W-1:0]                   count;
    } t_job;

    // finished result
    typedef struct packed {
        logic [IDX_W-1:0]                   pixel_index;
        logic [CHANNELS-1:0][AVG_W-1:0]     avg;
    } t_result;

    // back end status seen by the front
    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

`default_nettype wire

>>> hdl/pixel_sample_accumulator.sv
// top level of the progressive per-pixel sample accumulator
//
// channel   direction  handshake                   payload
// cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_image_width
// sample    in         i_valid / o_ready           column, row, rgb sample, count
// result    out        o_valid / i_ready           pixel index, averaged rgb
//
// the back end takes one item at a time (store read, add and write back, divider steps at two
// quotient bits each, result load), popping the next after loading; the divider sets the rate
// the front pipeline queues up to 4 requests ahead of the back end
// after reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT sum store entries
// (65536 at defaults), with o_ready low; configuration writes are taken meanwhile
// a held output result stalls the back end; the front accepts until queue and pipeline fill
`default_nettype none

module pixel_sample_accumulator
    import psa_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_image_width,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [COL_W-1:0] i_column,
    input  logic [ROW_W-1:0] i_row_number,
    input  logic [SMP_W-1:0] i_sample_red,
    input  logic [SMP_W-1:0] i_sample_green,
    input  logic [SMP_W-1:0] i_sample_blue,
    input  logic [CNT_W-1:0] i_sample_count,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [IDX_W-1:0] o_pixel_index,
    output logic [AVG_W-1:0] o_avg_red,
    output logic [AVG_W-1:0] o_avg_green,
    output logic [AVG_W-1:0] o_avg_blue
);

    localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int Q_W    = $bits(t_job) + ADDR_W;

    t_back_status      w_back_status;
    logic              w_push;
    t_job              w_push_job;
    logic [ADDR_W-1:0] w_push_addr;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;
    logic [Q_W-1:0]    w_head;
    t_job              w_head_job;
    logic [ADDR_W-1:0] w_head_addr;
    t_result           w_result;

    // front end
    psa_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXELS    (PIXELS),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_image_width (i_cfg_image_width),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_column          (i_column),
        .i_row_number      (i_row_number),
        .i_sample_red      (i_sample_red),
        .i_sample_green    (i_sample_green),
        .i_sample_blue     (i_sample_blue),
        .i_sample_count    (i_sample_count),
        .i_back_status     (w_back_status),
        .o_push            (w_push),
        .o_push_job        (w_push_job),
        .o_push_addr       (w_push_addr),
        .i_full            (w_full)
    );

    // request queue
    psa_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data ({w_push_job, w_push_addr}),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_head),
        .o_empty     (w_empty)
    );

    assign w_head_job  = w_head[Q_W-1:ADDR_W];
    assign w_head_addr = w_head[ADDR_W-1:0];

    // back end
    psa_back #(
        .PIXELS (PIXELS),
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (!w_empty),
        .i_job         (w_head_job),
        .i_job_addr    (w_head_addr),
        .o_job_pop     (w_pop),
        .o_back_status (w_back_status),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (w_result)
    );

    assign o_pixel_index = w_result.pixel_index;
    assign o_avg_red     = w_result.avg[CH_RED];
    assign o_avg_green   = w_result.avg[CH_GREEN];
    assign o_avg_blue    = w_result.avg[CH_BLUE];

endmodule

`default_nettype wire

>>> hdl/psa_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module psa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/psa_fifo.sv
// small register queue between the front and back ends
`default_nettype none

module psa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [LVL_W-1:0] r_level;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [LVL_W-1:0] n_level;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign o_full     = (r_level == LVL_W'(DEPTH));
    assign o_empty    = (r_level == '0);
    assign o_pop_data = r_mem[r_rptr];
    assign w_push_ok  = i_push && !o_full;
    assign w_pop_ok   = i_pop && !o_empty;

    // pointer and level update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_level = r_level;
        if (w_push_ok) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop_ok) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_push_ok && !w_pop_ok) begin
            n_level = r_level + 1'b1;
        end else if (w_pop_ok && !w_push_ok) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/psa_front.sv
// front end: width register, linear index and store address pipeline
`default_nettype none

module psa_front
    import psa_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int PIXELS    = 65536,
    parameter int ADDR_W    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_image_width,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [COL_W-1:0]  i_column,
    input  logic [ROW_W-1:0]  i_row_number,
    input  logic [SMP_W-1:0]  i_sample_red,
    input  logic [SMP_W-1:0]  i_sample_green,
    input  logic [SMP_W-1:0]  i_sample_blue,
    input  logic [CNT_W-1:0]  i_sample_count,
    input  t_back_status      i_back_status,
    output logic              o_push,
    output t_job              o_push_job,
    output logic [ADDR_W-1:0] o_push_addr,
    input  logic              i_full
);

    localparam int CFG_MAX   = (1 << CFG_W) - 1;
    localparam int WEFF_MAX  = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
    localparam int EW_W      = $clog2(WEFF_MAX + 1);
    localparam int RST_WIDTH = (CFG_RESET_WIDTH > WEFF_MAX) ? WEFF_MAX : CFG_RESET_WIDTH;
    localparam int LIN_MAX   = ((1 << COL_W) - 1) + ((1 << ROW_W) - 1) * WEFF_MAX;
    localparam int LIN_W     = $clog2(LIN_MAX + 1);
    localparam int RCP_W     = LIN_W + 1;
    localparam int RECIP     = (1 << LIN_W) / PIXELS;

    logic [EW_W-1:0]          r_eff_width;
    logic [EW_W-1:0]          n_eff_width;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic [LIN_W-1:0]         r_lin1;
    logic [LIN_W-1:0]         r_lin2;
    logic [LIN_W-1:0]         r_qest2;
    logic [ADDR_W-1:0]        r_addr3;
    t_job                     r_job1;
    t_job                     r_job2;
    t_job                     r_job3;
    logic                     w_en;
    logic                     w_accept;
    logic [LIN_W-1:0]         w_lin;
    t_job                     w_job;
    logic [LIN_W+RCP_W-1:0]   w_prod;
    logic [LIN_W-1:0]         w_qest;
    logic [LIN_W-1:0]         w_back;
    logic [LIN_W-1:0]         w_rem;
    logic [LIN_W-1:0]         w_rem_fix;

    assign o_cfg_ready = 1'b1;

    // width clamp to one .. max width
    always_comb begin
        if (i_cfg_image_width == '0) begin
            n_eff_width = EW_W'(1);
        end else if (int'(i_cfg_image_width) > WEFF_MAX) begin
            n_eff_width = EW_W'(WEFF_MAX);
        end else begin
            n_eff_width = EW_W'(i_cfg_image_width);
        end
    end

    // pipeline advance: stall only when the last stage cannot push
    assign w_en     = !r_v3 || !i_full;
    assign o_ready  = w_en && !i_back_status.clearing;
    assign w_accept = i_valid && o_ready;

    // stage one: linear index and count clamp
    assign w_lin = LIN_W'(i_column) + LIN_W'(i_row_number) * LIN_W'(r_eff_width);

    always_comb begin
        w_job                     = '0;
        w_job.pixel_index         = IDX_W'(w_lin);
        w_job.sample[CH_RED]      = i_sample_red;
        w_job.sample[CH_GREEN]    = i_sample_green;
        w_job.sample[CH_BLUE]     = i_sample_blue;
        w_job.count               = (i_sample_count == '0) ? CNT_W'(1) : i_sample_count;
    end

    // stage two: quotient estimate by reciprocal, low by at most one
    assign w_prod = r_lin1 * RCP_W'(RECIP);
    assign w_qest = w_prod[2*LIN_W-1:LIN_W];

    // stage three: remainder with one correction step
    assign w_back    = LIN_W'(r_qest2 * PIXELS);
    assign w_rem     = r_lin2 - w_back;
    assign w_rem_fix = (32'(w_rem) >= 32'(PIXELS)) ? w_rem - LIN_W'(PIXELS) : w_rem;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_width <= EW_W'(RST_WIDTH);
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_eff_width <= n_eff_width;
            end
            if (w_en) begin
                r_v1 <= w_accept;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lin1  <= w_lin;
            r_job1  <= w_job;
            r_lin2  <= r_lin1;
            r_qest2 <= w_qest;
            r_job2  <= r_job1;
            r_addr3 <= ADDR_W'(w_rem_fix);
            r_job3  <= r_job2;
        end
    end

    assign o_push      = r_v3;
    assign o_push_job  = r_job3;
    assign o_push_addr = r_addr3;

endmodule

`default_nettype wire

>>> hdl/psa_back.sv
// back end: store clearing, read-modify-write of sums, divider, result register
`default_nettype none
`include "pixel_sample_accumulator_defines.svh"

module psa_back
    import psa_pkg::*;
#(
    parameter int PIXELS = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  t_job              i_job,
    input  logic [ADDR_W-1:0] i_job_addr,
    output logic              o_job_pop,
    output t_back_status      o_back_status,
    output logic              o_valid,
    input  logic              i_ready,
    output t_result           o_result
);

    localparam int ST_W     = 3;
    localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
    localparam logic [ST_W-1:0] ST_READ  = 3'd2;
    localparam logic [ST_W-1:0] ST_DIV   = 3'd3;
    localparam logic [ST_W-1:0] ST_DONE  = 3'd4;
    localparam int STEP_W   = $clog2(DIV_STEPS);
    localparam int DVS_W    = CNT_W + QUO_W - 1;

    logic [ST_W-1:0]                    r_state;
    logic [ST_W-1:0]                    n_state;
    logic [ADDR_W-1:0]                  r_clr_addr;
    logic [ADDR_W-1:0]                  n_clr_addr;
    logic [STEP_W-1:0]                  r_step;
    logic [STEP_W-1:0]                  n_step;
    logic                               r_out_valid;
    logic                               n_out_valid;
    t_result                            r_out;
    t_job                               r_job;
    logic [ADDR_W-1:0]                  r_addr;
    logic [SUM_W-1:0]                   r_limit;
    logic [CHANNELS-1:0][SUM_W-1:0]     r_rem;
    logic [CHANNELS-1:0]                r_over;
    logic [CHANNELS-1:0][QUO_W-1:0]     r_quo;
    logic [DVS_W-1:0]                   r_dvs;
    logic                               w_out_load;
    logic                               w_ram_we;
    logic [ADDR_W-1:0]                  w_ram_waddr;
    logic [CHANNELS-1:0][SUM_W-1:0]     w_ram_wdata;
    logic                               w_ram_re;
    logic [CHANNELS-1:0][SUM_W-1:0]     w_ram_rdata;
    logic [CHANNELS-1:0][SUM_W-1:0]     w_sum;
    logic [CHANNELS-1:0][SUM_W-1:0]     w_div_rem;
    logic [CHANNELS-1:0][DIV_BITS-1:0]  w_div_bits;

    // one sum store per channel
    for (genvar g = 0; g < CHANNELS; g++) begin : g_ram
        psa_ram #(
            .WIDTH  (SUM_W),
            .DEPTH  (PIXELS),
            .ADDR_W (ADDR_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_ram_we),
            .i_waddr (w_ram_waddr),
            .i_wdata (w_ram_wdata[g]),
            .i_re    (w_ram_re),
            .i_raddr (i_job_addr),
            .o_rdata (w_ram_rdata[g])
        );
    end

    // saturating add of the new sample
    always_comb begin
        logic [SUM_W:0] wide;
        for (int c = 0; c < CHANNELS; c++) begin
            wide     = {1'b0, w_ram_rdata[c]} + (SUM_W + 1)'(r_job.sample[c]);
            w_sum[c] = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
        end
    end

    // restoring divide, two quotient bits per cycle
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_div_rem[c] = r_rem[c];
            for (int j = 0; j < DIV_BITS; j++) begin
                if (w_div_rem[c] >= SUM_W'(r_dvs >> j)) begin
                    w_div_rem[c]               = w_div_rem[c] - SUM_W'(r_dvs >> j);
                    w_div_bits[c][DIV_BITS-1-j] = 1'b1;
                end else begin
                    w_div_bits[c][DIV_BITS-1-j] = 1'b0;
                end
            end
        end
    end

    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_step      = r_step;
        o_job_pop   = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_waddr = r_addr;
        w_ram_wdata = w_sum;
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(PIXELS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    w_ram_re  = 1'b1;
                    n_state   = ST_READ;
                end
            end
            ST_READ: begin
                w_ram_we = 1'b1;
                n_step   = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // result register valid
    always_comb begin
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job   <= i_job;
            r_addr  <= i_job_addr;
            r_limit <= (SUM_W'(i_job.count) << FRAC_BITS) + SUM_W'(i_job.count);
        end
        if (r_state == ST_READ) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_rem[c]  <= w_sum[c];
                r_over[c] <= (w_sum[c] >= r_limit);
                r_quo[c]  <= '0;
            end
            r_dvs <= DVS_W'(r_job.count) << (QUO_W - 1);
        end
        if (r_state == ST_DIV) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_rem[c] <= w_div_rem[c];
                r_quo[c] <= {r_quo[c][QUO_W-DIV_BITS-1:0], w_div_bits[c]};
            end
            r_dvs <= r_dvs >> DIV_BITS;
        end
        if (w_out_load) begin
            r_out.pixel_index <= r_job.pixel_index;
            for (int c = 0; c < CHANNELS; c++) begin
                r_out.avg[c] <= r_over[c] ? AVG_W'(ONE_Q12) : AVG_W'(r_quo[c]);
            end
        end
    end

    assign o_back_status.clearing = (r_state == ST_CLEAR);
    assign o_valid                = r_out_valid;
    assign o_result               = r_out;

    // checks
    `PSA_ASSERT_IMP(a_no_pop_in_clear, i_clk, i_rst_n, r_state == ST_CLEAR, !o_job_pop)
    `PSA_ASSERT_NXT(a_read_then_div, i_clk, i_rst_n, r_state == ST_READ, r_state == ST_DIV)
    `PSA_ASSERT_IMP(a_avg_clamped, i_clk, i_rst_n, r_out_valid, (r_out.avg[CH_RED] <= AVG_W'(ONE_Q12)) && (r_out.avg[CH_GREEN] <= AVG_W'(ONE_Q12)) && (r_out.avg[CH_BLUE] <= AVG_W'(ONE_Q12)))

endmodule

`default_nettype wire
